// ===== rtl/rwsp_pkg.sv =====
`timescale 1ns / 1ps
package rwsp_pkg;

  localparam int NUM_W = 21;  // left-aligned dividend bits, widest quotient

  localparam logic [1:0] REG_TILE_UNITS  = 2'd0;
  localparam logic [1:0] REG_PROJ_DIST   = 2'd1;
  localparam logic [1:0] REG_WALL_COLOR  = 2'd2;
  localparam logic [1:0] REG_ERASE_COLOR = 2'd3;

  localparam logic [8:0]  TILE_UNITS_RST  = 9'd64;
  localparam logic [23:0] PROJ_DIST_RST   = 24'd141312;
  localparam logic [23:0] WALL_COLOR_RST  = 24'hFFFF00;
  localparam logic [23:0] ERASE_COLOR_RST = 24'h000000;

  // cosine polynomial coefficients, Q1.15
  localparam logic [15:0] COS_C1 = 16'd684;
  localparam logic [15:0] COS_C2 = 16'd8312;
  localparam logic [15:0] COS_C3 = 16'd40426;
  localparam logic [15:0] COS_C4 = 16'd30;
  localparam logic [16:0] COS_ONE = 17'd32768;

  typedef struct packed {
    logic [9:0]  column;
    logic [23:0] ray_distance;
    logic [15:0] ray_angle;
    logic [15:0] view_angle;
    logic        erase;
  } in_beat_t;

  typedef struct packed {
    logic [9:0]  out_column;
    logic [9:0]  top_row;
    logic [9:0]  bottom_row;
    logic [23:0] fill_color;
  } out_beat_t;

  typedef struct packed {
    logic [9:0]  column;
    logic        col_ok;
    logic        zero;
    logic        neg;
    logic [23:0] color;
  } side_t;

  typedef struct packed {
    logic [23:0]      rem;
    logic [23:0]      mag;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] quo;
    logic             sat;
    side_t            side;
  } div_beat_t;

endpackage

// ===== rtl/rwsp_div_cell.sv =====
`timescale 1ns / 1ps
module rwsp_div_cell import rwsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  div_beat_t in_beat,
  output logic      out_valid,
  output div_beat_t out_beat
);

  logic      valid_r;
  div_beat_t beat_r;
  div_beat_t beat_nxt;
  logic [24:0] trial;
  logic [24:0] diff;
  logic        ge;

  // one restoring step: one quotient bit per cell
  always_comb begin
    trial = {in_beat.rem, in_beat.num[NUM_W-1]};
    diff  = trial - {1'b0, in_beat.mag};
    ge    = trial >= {1'b0, in_beat.mag};
    beat_nxt     = in_beat;
    beat_nxt.rem = ge ? diff[23:0] : trial[23:0];
    beat_nxt.num = {in_beat.num[NUM_W-2:0], 1'b0};
    beat_nxt.quo = {in_beat.quo[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

endmodule

// ===== rtl/raycast_wall_slice_projection.sv =====
`timescale 1ns / 1ps
// Wall column projection for a ray caster.
// Input channel (in_valid/in_ready/in_beat): one ray per beat with its column,
// hit distance, ray angle, view angle and erase flag.
// Output channel (out_valid/out_ready/out_beat): one span per ray, in order:
// column, top row, bottom row (exclusive) and fill color.
// Config: APB-style write/read port, registers tile units, projection_distance,
// wall_color, erase_color at byte addresses 0, 4, 8, 12. Write only while idle.
// Pipeline: 8 stages of cosine, distance and range check, one divider cell
// per quotient bit, and the output register.
// Throughput: one ray per cycle unless the output stalls with the pipeline full;
// every stage and divider cell takes a new beat each cycle it is enabled.
// Stall: a stage holds while it and all stages after it are full and the
// output is stalled; empty stages keep filling, so the block still takes
// beats while a result waits.
// Reset: pipeline emptied, registers to their reset values.
module raycast_wall_slice_projection import rwsp_pkg::*; #(
  parameter int SCREEN_HEIGHT = 512,
  parameter int RAY_COUNT     = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_beat,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_beat,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int QB    = $clog2(SCREEN_HEIGHT) + 9;
  localparam int NPRE  = 8;
  localparam int NST   = NPRE + QB + 1;
  localparam logic [QB:0] SATQ = (QB+1)'(SCREEN_HEIGHT * 256);
  localparam logic [QB:0] MIDQ = (QB+1)'((SCREEN_HEIGHT / 2) * 256);
  localparam logic [QB:0] SHQ  = (QB+1)'(SCREEN_HEIGHT);
  localparam logic [9:0]  MIDR = 10'(SCREEN_HEIGHT / 2);
  localparam logic [12:0] RCQ  = 13'(RAY_COUNT);

  // config registers
  logic [8:0]  tile_units_r;
  logic [23:0] proj_dist_r;
  logic [23:0] wall_color_r;
  logic [23:0] erase_color_r;
  logic [39:0] num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_units_r  <= TILE_UNITS_RST;
      proj_dist_r   <= PROJ_DIST_RST;
      wall_color_r  <= WALL_COLOR_RST;
      erase_color_r <= ERASE_COLOR_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_TILE_UNITS:  tile_units_r  <= pwdata[8:0];
        REG_PROJ_DIST:   proj_dist_r   <= pwdata[23:0];
        REG_WALL_COLOR:  wall_color_r  <= pwdata[23:0];
        REG_ERASE_COLOR: erase_color_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TILE_UNITS:  prdata = {23'd0, tile_units_r};
      REG_PROJ_DIST:   prdata = {8'd0, proj_dist_r};
      REG_WALL_COLOR:  prdata = {8'd0, wall_color_r};
      REG_ERASE_COLOR: prdata = {8'd0, erase_color_r};
      default:         prdata = 32'd0;
    endcase
  end

  assign pready = 1'b1;

  // dividend, recomputed every cycle from the (quiet) registers
  logic [32:0] tp_prod;
  assign tp_prod = tile_units_r * proj_dist_r;
  always_ff @(posedge clk) begin
    num_r <= {tp_prod[32:0], 7'd0};
  end

  // stage enables: a stage loads when the output is ready or any stage at or after it is empty
  logic [NST-1:0] vld;
  logic [NST-1:0] en;
  genvar gk;
  generate
    for (gk = 0; gk < NST; gk++) begin : g_en
      assign en[gk] = out_ready | ~(&vld[NST-1:gk]);
    end
  endgenerate

  assign in_ready = en[0];

  logic [NPRE-1:0] vpre_r;
  assign vld[NPRE-1:0] = vpre_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpre_r <= '0;
    end else begin
      if (en[0]) vpre_r[0] <= in_valid;
      for (int k = 1; k < NPRE; k++) begin
        if (en[k]) vpre_r[k] <= vpre_r[k-1];
      end
    end
  end

  // stage 1: angle fold
  logic [15:0] diff_a;
  logic [1:0]  quad;
  logic [14:0] fold;
  side_t       side_nxt;
  logic [15:0] u_r;
  logic [23:0] dist_r [1:NPRE-2];
  side_t       side_r [1:NPRE-1];

  always_comb begin
    diff_a = in_beat.ray_angle - in_beat.view_angle;
    quad   = diff_a[15:14];
    fold   = quad[0] ? (15'd16384 - {1'b0, diff_a[13:0]}) : {1'b0, diff_a[13:0]};
    side_nxt.column = in_beat.column;
    side_nxt.col_ok = {3'd0, in_beat.column} < RCQ;
    side_nxt.zero   = 1'b0;
    side_nxt.neg    = quad[1] ^ quad[0];
    side_nxt.color  = in_beat.erase ? erase_color_r : wall_color_r;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      u_r       <= {fold, 1'b0};
      dist_r[1] <= in_beat.ray_distance;
      side_r[1] <= side_nxt;
    end
    for (int k = 2; k <= NPRE - 2; k++) begin
      if (en[k-1]) dist_r[k] <= dist_r[k-1];
    end
    for (int k = 2; k <= NPRE - 1; k++) begin
      if (en[k-1]) side_r[k] <= side_r[k-1];
    end
  end

  // stages 2..6: cosine polynomial, one multiply per stage
  logic [31:0] sq;
  logic [15:0] u2_r [2:5];
  logic [20:0] m3;
  logic [25:0] m4;
  logic [29:0] m5;
  logic [31:0] m6;
  logic [9:0]  t1_r;
  logic [13:0] t2_r;
  logic [15:0] t3_r;
  logic [15:0] cos_r;
  logic [15:0] cos_nxt;
  logic [16:0] p6;

  assign sq = u_r * u_r;
  assign m3 = u2_r[2] * COS_C4[4:0];
  assign m4 = t1_r * u2_r[3];
  assign m5 = t2_r * u2_r[4];
  assign m6 = t3_r * u2_r[5];
  assign p6 = m6[31:15];
  assign cos_nxt = (p6 >= COS_ONE) ? 16'd0 : 16'(COS_ONE - p6);

  always_ff @(posedge clk) begin
    if (en[1]) u2_r[2] <= sq[30:15];
    if (en[2]) begin
      u2_r[3] <= u2_r[2];
      t1_r    <= 10'(COS_C1 - {10'd0, m3[20:15]});
    end
    if (en[3]) begin
      u2_r[4] <= u2_r[3];
      t2_r    <= 14'(COS_C2 - {5'd0, m4[25:15]});
    end
    if (en[4]) begin
      u2_r[5] <= u2_r[4];
      t3_r    <= COS_C3 - {1'b0, m5[29:15]};
    end
    if (en[5]) cos_r <= cos_nxt;
  end

  // stage 7: perpendicular distance
  logic [39:0] m7;
  logic [23:0] mag_r;
  side_t       side7;
  assign m7 = dist_r[NPRE-2] * cos_r;

  always_comb begin
    side7      = side_r[6];
    side7.zero = (m7[38:15] == 24'd0);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      mag_r     <= m7[38:15];
      side_r[7] <= side7;
    end
  end

  // stage 8: saturation check and divider setup
  logic [39:0]      hi_part;
  logic [NUM_W-1:0] nlo;
  div_beat_t        chain [0:QB];
  logic [QB:0]      cvld;

  assign hi_part = num_r >> QB;
  assign nlo     = NUM_W'(num_r[QB-1:0]) << (NUM_W - QB);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      chain[0].rem  <= hi_part[23:0];
      chain[0].mag  <= mag_r;
      chain[0].num  <= nlo;
      chain[0].quo  <= '0;
      chain[0].sat  <= hi_part >= {16'd0, mag_r};
      chain[0].side <= side_r[7];
    end
  end

  assign cvld[0] = vpre_r[NPRE-1];

  generate
    for (gk = 0; gk < QB; gk++) begin : g_cell
      rwsp_div_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en[NPRE+gk]),
        .in_valid  (cvld[gk]),
        .in_beat   (chain[gk]),
        .out_valid (cvld[gk+1]),
        .out_beat  (chain[gk+1])
      );
      assign vld[NPRE+gk] = cvld[gk+1];
    end
  endgenerate

  // final span and output register
  div_beat_t   fin;
  logic [QB:0] quo_q;
  logic [QB:0] half;
  logic [QB:0] top_q;
  logic [QB:0] bot_q;
  logic [QB:0] bot_c;
  out_beat_t   out_nxt;
  out_beat_t   out_beat_r;
  logic        out_valid_r;

  always_comb begin
    fin   = chain[QB];
    quo_q = {1'b0, fin.quo[QB-1:0]};
    half  = (fin.sat || quo_q > SATQ) ? SATQ : quo_q;
    top_q = (half >= MIDQ) ? '0 : ((MIDQ - half) >> 8);
    bot_q = (MIDQ + half) >> 8;
    bot_c = (bot_q > SHQ) ? SHQ : bot_q;
    out_nxt.out_column = fin.side.column;
    out_nxt.fill_color = fin.side.color;
    if (!fin.side.col_ok) begin
      out_nxt.top_row    = MIDR;
      out_nxt.bottom_row = MIDR;
    end else if (fin.side.zero) begin
      out_nxt.top_row    = 10'd0;
      out_nxt.bottom_row = 10'(SCREEN_HEIGHT);
    end else if (fin.side.neg) begin
      out_nxt.top_row    = MIDR;
      out_nxt.bottom_row = MIDR;
    end else begin
      out_nxt.top_row    = top_q[9:0];
      out_nxt.bottom_row = bot_c[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en[NST-1]) begin
      out_valid_r <= cvld[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) out_beat_r <= out_nxt;
  end

  assign vld[NST-1] = out_valid_r;
  assign out_valid  = out_valid_r;
  assign out_beat   = out_beat_r;

endmodule

// ===== rtl/rwsp_checker.sv =====
`timescale 1ns / 1ps
module rwsp_checker import rwsp_pkg::*; #(
  parameter int SCREEN_HEIGHT = 512
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_beat
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("stalled output beat changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_beat.top_row <= out_beat.bottom_row)
    else $error("span top below bottom");

  a_span_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {3'd0, out_beat.bottom_row} <= 13'(SCREEN_HEIGHT))
    else $error("span bottom past screen");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled with output draining");

endmodule

bind raycast_wall_slice_projection rwsp_checker #(
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_rwsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_beat  (out_beat)
);

// ===== dv/raycast_wall_slice_projection_tb.sv =====
`timescale 1ns / 1ps
module raycast_wall_slice_projection_tb import rwsp_pkg::*; ;

  localparam int SCREEN_H = 512;
  localparam int RAY_CNT = 1024;
  localparam int MID = SCREEN_H / 2;
  localparam int LAT = 40;
  localparam int CYCLE_LIMIT = 400000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_beat_t in_beat;
  out_beat_t out_beat;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  raycast_wall_slice_projection dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_beat(in_beat),
    .out_valid(out_valid), .out_ready(out_ready), .out_beat(out_beat),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow registers
  logic [8:0]  tile_q;
  logic [23:0] proj_q, wall_q, erase_q;

  in_beat_t  ray_q[$];
  out_beat_t span_q[$];
  int errors = 0;
  int cycles = 0;
  bit idle_ok = 1;
  int hold_off = 0;
  bit stall_go = 0;
  bit stall_done = 0;
  int src_gap = 0, snk_gap = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // long receiver stall, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off <= 0;
    end else if (stall_go && !stall_done) begin
      hold_off <= 300;
      stall_done <= 1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  function automatic logic [16:0] quarter_cosine(input logic [14:0] r);
    logic [63:0] u, u2, t, p;
    u = {49'd0, r} << 1;
    u2 = (u * u) >> 15;
    t = 64'd684 - ((64'd30 * u2) >> 15);
    t = 64'd8312 - ((t * u2) >> 15);
    t = 64'd40426 - ((t * u2) >> 15);
    p = (t * u2) >> 15;
    return (p >= 64'd32768) ? 17'd0 : 17'(64'd32768 - p);
  endfunction

  function automatic out_beat_t project_span(input in_beat_t b);
    out_beat_t o;
    logic [15:0] d;
    logic [1:0] q;
    logic [14:0] r;
    logic [16:0] c;
    logic neg;
    logic [63:0] mag, half, top, bot;
    d = b.ray_angle - b.view_angle;
    q = d[15:14];
    r = {1'b0, d[13:0]};
    case (q)
      2'd0: begin c = quarter_cosine(r); neg = 1'b0; end
      2'd1: begin c = quarter_cosine(15'd16384 - r); neg = 1'b1; end
      2'd2: begin c = quarter_cosine(r); neg = 1'b1; end
      default: begin c = quarter_cosine(15'd16384 - r); neg = 1'b0; end
    endcase
    mag = (64'(b.ray_distance) * 64'(c)) >> 15;
    if (b.column >= RAY_CNT) begin
      top = 64'(MID); bot = 64'(MID);
    end else if (mag == 64'd0) begin
      top = 64'd0; bot = 64'(SCREEN_H);
    end else if (neg) begin
      top = 64'(MID); bot = 64'(MID);
    end else begin
      half = ((64'(tile_q) * 64'(proj_q)) << 7) / mag;
      if (half > 64'(SCREEN_H * 256)) half = 64'(SCREEN_H * 256);
      top = (half >= 64'(MID * 256)) ? 64'd0 : (64'(MID * 256) - half) >> 8;
      bot = (64'(MID * 256) + half) >> 8;
      if (bot > 64'(SCREEN_H)) bot = 64'(SCREEN_H);
    end
    o.out_column = b.column;
    o.top_row = top[9:0];
    o.bottom_row = bot[9:0];
    o.fill_color = b.erase ? erase_q : wall_q;
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_beat <= '0;
    end else begin
      if (in_valid && in_ready) span_q.push_back(project_span(in_beat));
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_valid <= 0;
        end else if (ray_q.size() > 0) begin
          in_valid <= 1;
          in_beat <= ray_q.pop_front();
          if (idle_ok && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 7);
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_beat_t e;
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (span_q.size() == 0) begin
          $display("%0t unexpected beat: actual %p", $time, out_beat);
          errors <= errors + 1;
        end else begin
          e = span_q.pop_front();
          if (e.out_column != out_beat.out_column ||
              e.top_row != out_beat.top_row ||
              e.bottom_row != out_beat.bottom_row ||
              e.fill_color != out_beat.fill_color) begin
            $display("%0t mismatch: expected %p actual %p", $time, e, out_beat);
            errors <= errors + 1;
          end
        end
      end
      if (hold_off > 0) begin
        out_ready <= 0;
      end else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        if (idle_ok && $urandom_range(0, 5) == 0) snk_gap <= $urandom_range(1, 7);
      end
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_TILE_UNITS: tile_q = v[8:0];
      REG_PROJ_DIST:  proj_q = v[23:0];
      REG_WALL_COLOR: wall_q = v[23:0];
      default:        erase_q = v[23:0];
    endcase
  endtask

  task automatic drain();
    wait (ray_q.size() == 0 && !in_valid && span_q.size() == 0);
    repeat (LAT) @(posedge clk);
  endtask

  function automatic in_beat_t rand_ray();
    in_beat_t b;
    int k;
    b.column = 10'($urandom);
    b.erase = 1'($urandom);
    b.view_angle = 16'($urandom);
    k = $urandom_range(0, 9);
    if (k < 6) b.ray_angle = b.view_angle + 16'($urandom_range(0, 12000)) - 16'd6000;
    else b.ray_angle = 16'($urandom);
    case ($urandom_range(0, 4))
      0: b.ray_distance = 24'($urandom_range(0, 255));
      1: b.ray_distance = 24'($urandom_range(256, 65535));
      2: b.ray_distance = 24'($urandom);
      default: b.ray_distance = 24'($urandom_range(4096, 1 << 20));
    endcase
    return b;
  endfunction

  function automatic in_beat_t mk(input logic [9:0] c, input logic [23:0] d,
                                  input logic [15:0] ra, input logic [15:0] va,
                                  input logic e);
    in_beat_t b;
    b.column = c; b.ray_distance = d; b.ray_angle = ra; b.view_angle = va; b.erase = e;
    return b;
  endfunction

  initial begin
    tile_q = TILE_UNITS_RST; proj_q = PROJ_DIST_RST;
    wall_q = WALL_COLOR_RST; erase_q = ERASE_COLOR_RST;
    rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    // directed: reset settings
    ray_q.push_back(mk(0, 24'd0, 0, 0, 0));              // zero distance
    ray_q.push_back(mk(10'h3FF, 24'hFFFFFF, 16'hFFFF, 0, 1));
    ray_q.push_back(mk(5, 24'd1, 0, 0, 0));              // huge height
    ray_q.push_back(mk(6, 24'd2560, 16'h8000, 0, 0));    // behind viewer
    ray_q.push_back(mk(7, 24'd2560, 16'h4000, 0, 1));    // cosine near zero
    ray_q.push_back(mk(8, 24'd2560, 16'hC000, 0, 0));
    ray_q.push_back(mk(9, 24'd2560, 16'h3000, 16'h0100, 0));
    ray_q.push_back(mk(10, 24'd2560, 16'hD000, 16'h0000, 1));
    ray_q.push_back(mk(11, 24'hFFFFFF, 0, 16'hFFFF, 0));
    ray_q.push_back(mk(12, 24'd100000, 16'h1234, 16'h1000, 1));
    drain();
    cfg_write(REG_TILE_UNITS, 32'd256);
    cfg_write(REG_PROJ_DIST, 32'hFFFFFF);
    cfg_write(REG_WALL_COLOR, 32'hFFFFFF);
    cfg_write(REG_ERASE_COLOR, 32'h123456);
    ray_q.push_back(mk(1, 24'hFFFFFF, 0, 0, 0));
    ray_q.push_back(mk(2, 24'h800000, 16'h2000, 0, 1));
    ray_q.push_back(mk(3, 24'd3, 16'h9000, 0, 0));
    drain();
    cfg_write(REG_TILE_UNITS, 32'd1);
    cfg_write(REG_PROJ_DIST, 32'd1);
    cfg_write(REG_WALL_COLOR, 32'd0);
    cfg_write(REG_ERASE_COLOR, 32'hFFFFFF);
    ray_q.push_back(mk(1, 24'd1, 0, 0, 0));
    ray_q.push_back(mk(2, 24'hFFFFFF, 0, 0, 1));
    drain();
    cfg_write(REG_TILE_UNITS, 32'd0);                    // register zero
    ray_q.push_back(mk(4, 24'd500, 0, 0, 0));
    ray_q.push_back(mk(4, 24'd0, 0, 0, 1));
    drain();
    // random phases under varying settings
    for (int ph = 0; ph < 5; ph++) begin
      cfg_write(REG_TILE_UNITS, $urandom_range(1, 256));
      cfg_write(REG_PROJ_DIST, (ph == 0) ? 32'd141312 : $urandom_range(1, 24'hFFFFFF));
      cfg_write(REG_WALL_COLOR, $urandom & 32'hFFFFFF);
      cfg_write(REG_ERASE_COLOR, $urandom & 32'hFFFFFF);
      if (ph == 4) idle_ok = 0;
      for (int i = 0; i < 200; i++) ray_q.push_back(rand_ray());
      if (ph == 1) begin
        // long receiver stall while rays keep coming
        wait (ray_q.size() < 150);
        stall_go = 1;
      end
      drain();
    end
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
